/* src/tod_pkg.sv */
// Shared types and constants for the time-of-day counter.
`default_nettype none

package tod_pkg;

   typedef enum logic [2:0] {
      OP_SET_CHECKED = 3'd0,
      OP_SET_NORM    = 3'd1,
      OP_INC         = 3'd2,
      OP_DEC         = 3'd3,
      OP_ADD         = 3'd4,
      OP_SUB         = 3'd5,
      OP_DIFF        = 3'd6
   } op_type;

   localparam logic [11:0] HOUR_SECONDS   = 12'd3600;
   localparam logic [5:0]  MINUTE_SECONDS = 6'd60;
   localparam logic [4:0]  DAY_HOURS      = 5'd24;
   localparam logic [4:0]  MAX_HOUR       = 5'd23;
   localparam logic [5:0]  MAX_MINUTE     = 6'd59;

   // 86400 = 128 * 675: residue mod 675 of (x >>> 7), low 7 bits kept
   localparam logic [9:0]  DAY_ODD        = 10'd675;
   localparam logic [26:0] DAY_ODD_BIAS   = 27'd33554925;   // 675 * 49711 >= 2^25
   localparam logic [17:0] DAY_ODD_RECIP  = 18'd198842;     // ceil(2^27 / 675)
   localparam logic [12:0] HOUR_RECIP     = 13'd4661;       // ceil(2^24 / 3600)
   localparam logic [10:0] MINUTE_RECIP   = 11'd1093;       // ceil(2^16 / 60)

   typedef struct packed {
      logic [2:0]         op;
      logic signed [15:0] hours_in;
      logic signed [15:0] minutes_in;
      logic signed [15:0] seconds_in;
      logic signed [31:0] amount;
   } req_type;

   typedef struct packed {
      logic [2:0] op;
      logic       bad;
      logic [4:0] set_hours;
      logic [5:0] set_minutes;
      logic [5:0] set_seconds;
   } ctl_type;

   typedef struct packed {
      ctl_type     ctl;
      logic [16:0] total;
   } total_type;

   typedef struct packed {
      ctl_type     ctl;
      logic [16:0] total;
      logic [4:0]  hours;
      logic [5:0]  minutes;
      logic [5:0]  seconds;
   } digits_type;

endpackage

`default_nettype wire

/* src/tod_if.sv */
// Request and response channel interfaces of the time-of-day counter.
`default_nettype none

interface tod_req_if;
   logic              valid;
   logic              ready;
   logic [2:0]        op;
   logic signed [15:0] hours_in;
   logic signed [15:0] minutes_in;
   logic signed [15:0] seconds_in;
   logic signed [31:0] amount;

   modport source (output valid, op, hours_in, minutes_in, seconds_in, amount,
                   input ready);
   modport sink   (input valid, op, hours_in, minutes_in, seconds_in, amount,
                   output ready);
endinterface

interface tod_rsp_if;
   logic              valid;
   logic              ready;
   logic [4:0]        hours_out;
   logic [5:0]        minutes_out;
   logic [5:0]        seconds_out;
   logic              invalid_set;
   logic signed [17:0] difference;

   modport source (output valid, hours_out, minutes_out, seconds_out, invalid_set,
                   difference, input ready);
   modport sink   (input valid, hours_out, minutes_out, seconds_out, invalid_set,
                   difference, output ready);
endinterface

`default_nettype wire

/* src/tod_reduce.sv */
// Operand select and reduction modulo one day, two register stages.
`default_nettype none

module tod_reduce import tod_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_valid,
   output logic           in_ready,
   input  wire req_type   in_data,
   output logic           out_valid,
   input  wire logic      out_ready,
   output total_type      out_data
);

   logic signed [28:0] hx, mx, sx, given;
   logic signed [32:0] xsel;
   logic [26:0]        q_ext, u_in;
   logic [44:0]        prod;
   logic               bad;
   ctl_type            ctl_in;

   logic               a_valid_ff, a_ready;
   ctl_type            a_ctl_ff;
   logic [26:0]        a_u_ff;
   logic [16:0]        a_qe_ff;
   logic [6:0]         a_low_ff;

   logic [26:0]        qe675;
   logic [27:0]        d, r;
   logic               b_valid_ff, b_ready;
   total_type          b_data_ff, b_data_in;

   assign hx    = 29'(in_data.hours_in);
   assign mx    = 29'(in_data.minutes_in);
   assign sx    = 29'(in_data.seconds_in);
   assign given = hx * 29'sd3600 + mx * 29'sd60 + sx;

   always_comb begin
      case (in_data.op)
         OP_SET_NORM, OP_DIFF: xsel = 33'(given);
         OP_INC:               xsel = 33'sd1;
         OP_DEC:               xsel = -33'sd1;
         OP_ADD:               xsel = 33'(in_data.amount);
         OP_SUB:               xsel = -33'(in_data.amount);
         default:              xsel = 33'sd0;
      endcase
   end

   assign q_ext = {xsel[32], xsel[32:7]};
   assign u_in  = q_ext + DAY_ODD_BIAS;
   assign prod  = 45'(u_in) * 45'(DAY_ODD_RECIP);

   assign bad = (in_data.hours_in < 16'sd0) || (in_data.hours_in > 16'sd23) ||
                (in_data.minutes_in < 16'sd0) || (in_data.minutes_in > 16'sd59) ||
                (in_data.seconds_in < 16'sd0) || (in_data.seconds_in > 16'sd59);

   always_comb begin
      ctl_in.op          = in_data.op;
      ctl_in.bad         = bad;
      ctl_in.set_hours   = in_data.hours_in[4:0];
      ctl_in.set_minutes = in_data.minutes_in[5:0];
      ctl_in.set_seconds = in_data.seconds_in[5:0];
   end

   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= in_valid;
      end
      if (a_ready && in_valid) begin
         a_ctl_ff <= ctl_in;
         a_u_ff   <= u_in;
         a_qe_ff  <= prod[43:27];
         a_low_ff <= xsel[6:0];
      end
   end

   // quotient estimate may be one high: fold back once
   assign qe675 = 27'(a_qe_ff) * 27'(DAY_ODD);
   assign d     = {1'b0, a_u_ff} - {1'b0, qe675};
   assign r     = d[27] ? d + 28'(DAY_ODD) : d;

   always_comb begin
      b_data_in.ctl   = a_ctl_ff;
      b_data_in.total = {r[9:0], a_low_ff};
   end

   assign b_ready = !b_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
      if (b_ready && a_valid_ff) begin
         b_data_ff <= b_data_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_data  = b_data_ff;

endmodule

`default_nettype wire

/* src/tod_split.sv */
// Splits a second-of-day count into hours, minutes and seconds, two stages.
`default_nettype none

module tod_split import tod_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   output logic            in_ready,
   input  wire total_type  in_data,
   output logic            out_valid,
   input  wire logic       out_ready,
   output digits_type      out_data
);

   logic [29:0] h_prod;
   logic [4:0]  h_est, h_val;
   logic [16:0] h_est_sec, h_sec;
   logic [16:0] rem_full;

   logic        c_valid_ff, c_ready;
   total_type   c_data_ff;
   logic [4:0]  c_hours_ff;
   logic [11:0] c_rem_ff;

   logic [22:0] m_prod;
   logic [5:0]  m_est, m_val;
   logic [11:0] m_est_sec, m_sec, s_full;

   logic        d_valid_ff, d_ready;
   digits_type  d_data_ff, d_data_in;

   assign h_prod    = 30'(in_data.total) * 30'(HOUR_RECIP);
   assign h_est     = h_prod[28:24];
   assign h_est_sec = 17'(h_est) * 17'(HOUR_SECONDS);
   assign h_val     = (h_est_sec > in_data.total) ? h_est - 5'd1 : h_est;
   assign h_sec     = 17'(h_val) * 17'(HOUR_SECONDS);
   assign rem_full  = in_data.total - h_sec;

   assign c_ready  = !c_valid_ff || d_ready;
   assign in_ready = c_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (c_ready) begin
         c_valid_ff <= in_valid;
      end
      if (c_ready && in_valid) begin
         c_data_ff  <= in_data;
         c_hours_ff <= h_val;
         c_rem_ff   <= rem_full[11:0];
      end
   end

   assign m_prod    = 23'(c_rem_ff) * 23'(MINUTE_RECIP);
   assign m_est     = m_prod[21:16];
   assign m_est_sec = 12'(m_est) * 12'(MINUTE_SECONDS);
   assign m_val     = (m_est_sec > c_rem_ff) ? m_est - 6'd1 : m_est;
   assign m_sec     = 12'(m_val) * 12'(MINUTE_SECONDS);
   assign s_full    = c_rem_ff - m_sec;

   always_comb begin
      d_data_in.ctl     = c_data_ff.ctl;
      d_data_in.total   = c_data_ff.total;
      d_data_in.hours   = c_hours_ff;
      d_data_in.minutes = m_val;
      d_data_in.seconds = s_full[5:0];
   end

   assign d_ready = !d_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (d_ready) begin
         d_valid_ff <= c_valid_ff;
      end
      if (d_ready && c_valid_ff) begin
         d_data_ff <= d_data_in;
      end
   end

   assign out_valid = d_valid_ff;
   assign out_data  = d_data_ff;

endmodule

`default_nettype wire

/* src/tod_core.sv */
// Time-of-day state, per-op update and the response register.
`default_nettype none

module tod_core import tod_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire digits_type  in_data,
   output logic             out_valid,
   input  wire logic        out_ready,
   output logic [4:0]       out_hours,
   output logic [5:0]       out_minutes,
   output logic [5:0]       out_seconds,
   output logic             out_invalid,
   output logic [17:0]      out_difference
);

   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  minute_ff, minute_in;
   logic [5:0]  second_ff, second_in;

   logic        rsp_valid_ff;
   logic        invalid_ff, invalid_in;
   logic [17:0] diff_ff, diff_in;

   logic        fire;
   logic [6:0]  sum_s, sum_m;
   logic [5:0]  sum_h;
   logic        carry_s, carry_m;
   logic [5:0]  add_s, add_m;
   logic [4:0]  add_h;
   logic [16:0] cur_total;

   assign sum_s   = 7'(second_ff) + 7'(in_data.seconds);
   assign carry_s = sum_s >= 7'(MINUTE_SECONDS);
   assign add_s   = carry_s ? 6'(sum_s - 7'(MINUTE_SECONDS)) : sum_s[5:0];

   assign sum_m   = 7'(minute_ff) + 7'(in_data.minutes) + 7'(carry_s);
   assign carry_m = sum_m >= 7'(MINUTE_SECONDS);
   assign add_m   = carry_m ? 6'(sum_m - 7'(MINUTE_SECONDS)) : sum_m[5:0];

   assign sum_h   = 6'(hour_ff) + 6'(in_data.hours) + 6'(carry_m);
   assign add_h   = (sum_h >= 6'(DAY_HOURS)) ? 5'(sum_h - 6'(DAY_HOURS)) : sum_h[4:0];

   assign cur_total = 17'(hour_ff) * 17'(HOUR_SECONDS) + 17'(minute_ff) * 17'(MINUTE_SECONDS)
                      + 17'(second_ff);

   always_comb begin
      hour_in    = hour_ff;
      minute_in  = minute_ff;
      second_in  = second_ff;
      invalid_in = 1'b0;
      diff_in    = '0;
      case (in_data.ctl.op)
         OP_SET_CHECKED: begin
            if (in_data.ctl.bad) begin
               invalid_in = 1'b1;
            end else begin
               hour_in   = in_data.ctl.set_hours;
               minute_in = in_data.ctl.set_minutes;
               second_in = in_data.ctl.set_seconds;
            end
         end
         OP_SET_NORM: begin
            hour_in   = in_data.hours;
            minute_in = in_data.minutes;
            second_in = in_data.seconds;
         end
         OP_INC, OP_DEC, OP_ADD, OP_SUB: begin
            hour_in   = add_h;
            minute_in = add_m;
            second_in = add_s;
         end
         OP_DIFF: begin
            diff_in = 18'(cur_total) - 18'(in_data.total);
         end
         default: begin
         end
      endcase
   end

   assign in_ready = !rsp_valid_ff || out_ready;
   assign fire     = in_ready && in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         hour_ff      <= '0;
         minute_ff    <= '0;
         second_ff    <= '0;
      end else begin
         if (in_ready) begin
            rsp_valid_ff <= in_valid;
         end
         if (fire) begin
            hour_ff   <= hour_in;
            minute_ff <= minute_in;
            second_ff <= second_in;
         end
      end
      if (fire) begin
         invalid_ff <= invalid_in;
         diff_ff    <= diff_in;
      end
   end

   assign out_valid      = rsp_valid_ff;
   assign out_hours      = hour_ff;
   assign out_minutes    = minute_ff;
   assign out_seconds    = second_ff;
   assign out_invalid    = invalid_ff;
   assign out_difference = diff_ff;

endmodule

`default_nettype wire

/* src/time_of_day_clock_top.sv */
// Time-of-day counter. Throughput is one beat per cycle while the response side
// does not stall; the only loop is the hours/minutes/seconds update in the last
// stage, which closes through the state registers.
// Stages: request register, day reduction (2), digit split (2), state/response.
// Reset (synchronous) sets the time to 00:00:00 and empties every stage.
`default_nettype none

module time_of_day_clock_top import tod_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   tod_req_if.sink     req_bus,
   tod_rsp_if.source   rsp_bus
);

   logic       req_valid_ff;
   req_type    req_data_ff, req_data_in;
   logic       req_ready;

   logic       red_ready;
   logic       red_valid, split_ready;
   total_type  red_data;
   logic       split_valid, core_ready;
   digits_type split_data;

   always_comb begin
      req_data_in.op         = req_bus.op;
      req_data_in.hours_in   = req_bus.hours_in;
      req_data_in.minutes_in = req_bus.minutes_in;
      req_data_in.seconds_in = req_bus.seconds_in;
      req_data_in.amount     = req_bus.amount;
   end

   assign req_ready     = !req_valid_ff || red_ready;
   assign req_bus.ready = req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_bus.valid;
      end
      if (req_ready && req_bus.valid) begin
         req_data_ff <= req_data_in;
      end
   end

   tod_reduce u_reduce (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid_ff),
      .in_ready  (red_ready),
      .in_data   (req_data_ff),
      .out_valid (red_valid),
      .out_ready (split_ready),
      .out_data  (red_data)
   );

   tod_split u_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (red_valid),
      .in_ready  (split_ready),
      .in_data   (red_data),
      .out_valid (split_valid),
      .out_ready (core_ready),
      .out_data  (split_data)
   );

   tod_core u_core (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (split_valid),
      .in_ready       (core_ready),
      .in_data        (split_data),
      .out_valid      (rsp_bus.valid),
      .out_ready      (rsp_bus.ready),
      .out_hours      (rsp_bus.hours_out),
      .out_minutes    (rsp_bus.minutes_out),
      .out_seconds    (rsp_bus.seconds_out),
      .out_invalid    (rsp_bus.invalid_set),
      .out_difference (rsp_bus.difference)
   );

endmodule

`default_nettype wire

/* bench/tod_check_pkg.sv */
// Time-of-day predictor and response scoreboard for the counter testbench.
package tod_check_pkg;
   import tod_pkg::*;

   localparam longint SECS_PER_DAY  = 86400;
   localparam longint SECS_PER_HOUR = 3600;
   localparam longint SECS_PER_MIN  = 60;
   localparam longint TOP_HOUR      = 23;
   localparam longint TOP_MINUTE    = 59;

   typedef struct packed {
      logic [4:0]  hours;
      logic [5:0]  minutes;
      logic [5:0]  seconds;
      logic        invalid;
      logic [17:0] difference;
   } tod_result;

   class tod_scoreboard;
      logic [4:0] hrs;
      logic [5:0] mins;
      logic [5:0] secs;
      tod_result  pending[$];
      int         errors;

      function new();
         hrs = '0;
         mins = '0;
         secs = '0;
         errors = 0;
      endfunction

      static function longint wrap_day(longint t);
         longint r;
         r = t % SECS_PER_DAY;
         if (r < 0) r += SECS_PER_DAY;
         return r;
      endfunction

      function void load_seconds(longint t);
         longint r;
         r = wrap_day(t);
         hrs  = 5'(r / SECS_PER_HOUR);
         mins = 6'((r % SECS_PER_HOUR) / SECS_PER_MIN);
         secs = 6'(r % SECS_PER_MIN);
      endfunction

      // advances the time by one request beat and returns the response it shows
      function tod_result advance_time(req_type r);
         tod_result res;
         longint    h, m, s, amt, given, now;
         h     = longint'($signed(r.hours_in));
         m     = longint'($signed(r.minutes_in));
         s     = longint'($signed(r.seconds_in));
         amt   = longint'($signed(r.amount));
         given = h * SECS_PER_HOUR + m * SECS_PER_MIN + s;
         now   = longint'(hrs) * SECS_PER_HOUR + longint'(mins) * SECS_PER_MIN
               + longint'(secs);
         res   = '0;
         case (r.op)
            OP_SET_CHECKED: begin
               if (h < 0 || h > TOP_HOUR || m < 0 || m > TOP_MINUTE ||
                   s < 0 || s > TOP_MINUTE) begin
                  res.invalid = 1'b1;
               end else begin
                  hrs  = 5'(h);
                  mins = 6'(m);
                  secs = 6'(s);
               end
            end
            OP_SET_NORM: load_seconds(given);
            OP_INC:      load_seconds(now + 1);
            OP_DEC:      load_seconds(now - 1);
            OP_ADD:      load_seconds(now + amt);
            OP_SUB:      load_seconds(now - amt);
            OP_DIFF:     res.difference = 18'(now - wrap_day(given));
            default: ;
         endcase
         res.hours   = hrs;
         res.minutes = mins;
         res.seconds = secs;
         return res;
      endfunction

      function void note_request(req_type r);
         pending.push_back(advance_time(r));
      endfunction

      function void check_response(tod_result got);
         tod_result want;
         if (pending.size() == 0) begin
            $error("response beat with nothing expected");
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.hours !== want.hours) begin
            $error("hours_out: expected %0d, got %0d", want.hours, got.hours);
            errors++;
         end
         if (got.minutes !== want.minutes) begin
            $error("minutes_out: expected %0d, got %0d", want.minutes, got.minutes);
            errors++;
         end
         if (got.seconds !== want.seconds) begin
            $error("seconds_out: expected %0d, got %0d", want.seconds, got.seconds);
            errors++;
         end
         if (got.invalid !== want.invalid) begin
            $error("invalid_set: expected %0d, got %0d", want.invalid, got.invalid);
            errors++;
         end
         if (got.difference !== want.difference) begin
            $error("difference: expected %0d, got %0d",
                   $signed(want.difference), $signed(got.difference));
            errors++;
         end
      endfunction
   endclass

endpackage

/* bench/testbench.sv */
// Top-level testbench: drives request beats, stalls responses, checks each one.
module testbench;
   import tod_pkg::*;
   import tod_check_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] OP_UNUSED = 3'd7;
   localparam int RANDOM_ITEMS = 1000;
   localparam int IDLE_LIMIT   = 2000;
   localparam int SETTLE       = 24;

   logic clock;
   logic reset;
   bit   calm;
   int   idle_cycles;

   tod_req_if req_bus();
   tod_rsp_if rsp_bus();

   tod_scoreboard sb = new();

   time_of_day_clock_top uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int draw_gap();
      return calm ? 0 : $urandom_range(0, 7);
   endfunction

   function automatic req_type make_req(logic [2:0] op, int h, int m, int s,
                                        logic signed [31:0] amt);
      req_type r;
      r.op         = op;
      r.hours_in   = 16'(h);
      r.minutes_in = 16'(m);
      r.seconds_in = 16'(s);
      r.amount     = amt;
      return r;
   endfunction

   function automatic req_type random_req();
      req_type r;
      int      pick;
      r.hours_in   = 16'($urandom);
      r.minutes_in = 16'($urandom);
      r.seconds_in = 16'($urandom);
      r.amount     = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 14)      r.op = OP_SET_CHECKED;
      else if (pick < 26) r.op = OP_SET_NORM;
      else if (pick < 41) r.op = OP_INC;
      else if (pick < 56) r.op = OP_DEC;
      else if (pick < 71) r.op = OP_ADD;
      else if (pick < 85) r.op = OP_SUB;
      else if (pick < 97) r.op = OP_DIFF;
      else                r.op = OP_UNUSED;
      case (r.op)
         OP_SET_CHECKED: begin
            pick = $urandom_range(0, 7);
            if (pick < 5) begin
               r.hours_in   = 16'($urandom_range(0, 23));
               r.minutes_in = 16'($urandom_range(0, 59));
               r.seconds_in = 16'($urandom_range(0, 59));
            end else if (pick == 5) begin
               r.hours_in   = 16'($urandom_range(0, 25) - 1);
               r.minutes_in = 16'($urandom_range(0, 61) - 1);
               r.seconds_in = 16'($urandom_range(0, 61) - 1);
            end
         end
         OP_SET_NORM, OP_DIFF: begin
            if ($urandom_range(0, 1) == 1) begin
               r.hours_in   = 16'($urandom_range(0, 100) - 50);
               r.minutes_in = 16'($urandom_range(0, 240) - 120);
               r.seconds_in = 16'($urandom_range(0, 240) - 120);
            end
         end
         OP_ADD, OP_SUB: begin
            pick = $urandom_range(0, 3);
            if (pick == 0)
               r.amount = $urandom_range(0, 200) - 100;
            else if (pick == 1)
               r.amount = ($urandom_range(0, 20) - 10) * 86400
                        + $urandom_range(0, 10) - 5;
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic send_req(req_type r);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.op         <= r.op;
      req_bus.hours_in   <= r.hours_in;
      req_bus.minutes_in <= r.minutes_in;
      req_bus.seconds_in <= r.seconds_in;
      req_bus.amount     <= r.amount;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_request(r);
   endtask

   task automatic wait_drained();
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   // response side: random stalls, one check per beat
   initial begin
      tod_result got;
      int        stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         got.hours      = rsp_bus.hours_out;
         got.minutes    = rsp_bus.minutes_out;
         got.seconds    = rsp_bus.seconds_out;
         got.invalid    = rsp_bus.invalid_set;
         got.difference = rsp_bus.difference;
         sb.check_response(got);
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      reset              <= 1'b1;
      calm               = 1'b0;
      req_bus.valid      <= 1'b0;
      req_bus.op         <= OP_SET_CHECKED;
      req_bus.hours_in   <= '0;
      req_bus.minutes_in <= '0;
      req_bus.seconds_in <= '0;
      req_bus.amount     <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // boundaries, rejects, wraparound
      send_req(make_req(OP_SET_CHECKED, 23, 59, 59, 0));
      send_req(make_req(OP_INC, 0, 0, 0, 0));
      send_req(make_req(OP_DEC, -1, -1, -1, -1));
      send_req(make_req(OP_DIFF, 0, 0, 0, 0));
      send_req(make_req(OP_SET_CHECKED, 0, 0, 0, 0));
      send_req(make_req(OP_DIFF, 23, 59, 59, 0));
      send_req(make_req(OP_SET_CHECKED, 24, 0, 0, 0));
      send_req(make_req(OP_SET_CHECKED, 0, 60, 0, 0));
      send_req(make_req(OP_SET_CHECKED, 0, 0, 60, 0));
      send_req(make_req(OP_SET_CHECKED, -1, 0, 0, 0));
      send_req(make_req(OP_SET_CHECKED, 0, -32768, 0, 0));
      send_req(make_req(OP_SET_CHECKED, 32767, 32767, -1, 0));
      send_req(make_req(OP_SET_NORM, -32768, -32768, -32768, 0));
      send_req(make_req(OP_SET_NORM, 32767, 32767, 32767, 0));
      send_req(make_req(OP_SET_NORM, 0, 0, -1, 0));
      send_req(make_req(OP_SET_NORM, 24, 0, 0, 0));
      send_req(make_req(OP_ADD, 0, 0, 0, 32'sh7fff_ffff));
      send_req(make_req(OP_ADD, 0, 0, 0, 32'sh8000_0000));
      send_req(make_req(OP_SUB, 0, 0, 0, 32'sh8000_0000));
      send_req(make_req(OP_SUB, 0, 0, 0, 32'sh7fff_ffff));
      send_req(make_req(OP_ADD, 0, 0, 0, 86400));
      send_req(make_req(OP_DIFF, -32768, -32768, -32768, 0));
      send_req(make_req(OP_DIFF, 32767, 32767, 32767, 0));
      send_req(make_req(OP_UNUSED, -1, -1, -1, -1));

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 64 == 0) calm = ($urandom_range(0, 3) == 0);
         if (i == RANDOM_ITEMS / 2 || $urandom_range(0, 99) == 0) begin
            req_bus.valid <= 1'b0;
            wait_drained();
         end
         send_req(random_req());
      end
      req_bus.valid <= 1'b0;

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
